// File: rtl/lbsc_pkg.sv
// ----------------------------------------------------------------------------
// lbsc_pkg: shared types and codes for the buffer slot cache
// Request kinds, response status codes and the controller state type.
// ----------------------------------------------------------------------------
package lbsc_pkg;

   localparam logic [1:0] KIND_LOOKUP   = 2'd0;
   localparam logic [1:0] KIND_OVERRIDE = 2'd1;
   localparam logic [1:0] KIND_UNCACHE  = 2'd2;

   localparam logic [1:0] ST_HIT     = 2'd0;
   localparam logic [1:0] ST_SEND    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

endpackage

// File: rtl/lru_buffer_slot_cache.sv
// ----------------------------------------------------------------------------
// lru_buffer_slot_cache: fully associative LRU buffer slot cache
// Maps 64-bit buffer ids onto a row of slot cells plus one override slot.
// ----------------------------------------------------------------------------
// Usage: a request (req_kind, req_buffer_id) is taken when req_valid is high
// and req_stall low. Kind 0 looks up or caches the id, kind 1 checks and
// sets the override id, kind 2 uncaches. One response (rsp_slot, rsp_status)
// follows per request and is held on rsp_valid until rsp_stall is low.
// In the cycle after acceptance the whole cell row compares the id and the
// update is committed at its end unless an eviction waits; the request then
// moves on to the response state, which raises rsp_valid. One request is in
// flight at a time: the next is taken only after the response is taken.
// The minimum stamp ripples through the cells one cell per cycle, so a
// lookup that misses with no free slot left waits in the execute state until
// the settle counter, reloaded with SLOTS on each table update, reaches zero.
// While a request is in flight, req_stall stays high.
// Reset empties all cells, clears the override, restores the free slot stack
// to slot 0 on top and zeroes the stamp counter.
// ----------------------------------------------------------------------------
module lru_buffer_slot_cache
   import lbsc_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic [63:0]                 req_buffer_id,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [6:0]                  rsp_slot,
   output logic [1:0]                  rsp_status
);
   localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   state_type   state_ff, state_in;
   logic [1:0]  kind_ff;
   logic [63:0] id_ff;
   logic [63:0] counter_ff;
   logic        ovr_valid_ff;
   logic [63:0] ovr_id_ff;
   logic [6:0]  slot_ff, slot_in;
   logic [1:0]  status_ff, status_in;
   logic [SlotW:0] settle_ff;

   logic [SLOTS-1:0]  match_vec;
   logic [SLOTS-1:0]  wr_vec, touch_vec, clr_vec;
   logic              chain_have  [SLOTS+1];
   logic [63:0]       chain_stamp [SLOTS+1];
   logic [SlotW-1:0]  chain_slot  [SLOTS+1];

   logic              hit;
   logic [SlotW-1:0]  hit_slot;
   logic              stk_empty, stk_pop, stk_push;
   logic [SlotW-1:0]  stk_top;
   logic [SlotW-1:0]  new_slot;
   logic              exec, ovr_match;
   logic              wait_min, go;

   assign chain_have[0]  = 1'b0;
   assign chain_stamp[0] = '0;
   assign chain_slot[0]  = '0;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      lbsc_cell #(.SlotW(SlotW)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .probe_id    (id_ff),
         .wr_en       (wr_vec[g]),
         .wr_stamp    (counter_ff),
         .touch_en    (touch_vec[g]),
         .clr_en      (clr_vec[g]),
         .my_slot     (SlotW'(g)),
         .min_have_i  (chain_have[g]),
         .min_stamp_i (chain_stamp[g]),
         .min_slot_i  (chain_slot[g]),
         .min_have_o  (chain_have[g+1]),
         .min_stamp_o (chain_stamp[g+1]),
         .min_slot_o  (chain_slot[g+1]),
         .match       (match_vec[g])
      );
   end

   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int k = SLOTS - 1; k >= 0; k--) begin
         if (match_vec[k]) begin
            hit      = 1'b1;
            hit_slot = SlotW'(k);
         end
      end
   end

   lbsc_free_stack #(.Slots(SLOTS), .SlotW(SlotW)) u_stack (
      .clock     (clock),
      .reset     (reset),
      .pop       (stk_pop),
      .push      (stk_push),
      .push_slot (hit_slot),
      .empty     (stk_empty),
      .top_slot  (stk_top)
   );

   assign exec      = (state_ff == S_EXEC);
   assign ovr_match = ovr_valid_ff && (ovr_id_ff == id_ff);
   // An eviction has to wait until the minimum has crossed the whole row.
   assign wait_min  = exec && (kind_ff == KIND_LOOKUP) && !hit && stk_empty &&
                      (settle_ff != '0);
   assign go        = exec && !wait_min;
   assign new_slot  = stk_empty ? chain_slot[SLOTS] : stk_top;
   assign stk_pop   = go && (kind_ff == KIND_LOOKUP) && !hit;
   assign stk_push  = go && (kind_ff == KIND_UNCACHE) && hit;

   always_comb begin
      wr_vec    = '0;
      touch_vec = '0;
      clr_vec   = '0;
      if (go && (kind_ff == KIND_LOOKUP)) begin
         if (hit) begin
            touch_vec[hit_slot] = 1'b1;
         end else begin
            wr_vec[new_slot] = 1'b1;
         end
      end
      if (stk_push) begin
         clr_vec[hit_slot] = 1'b1;
      end
   end

   // Next state.
   always_comb begin
      case (state_ff)
         S_IDLE:  state_in = req_valid ? S_EXEC : S_IDLE;
         S_EXEC:  state_in = wait_min ? S_EXEC : S_RESP;
         S_RESP:  state_in = rsp_stall ? S_RESP : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs and response values.
   always_comb begin
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_RESP);
      slot_in   = 7'd0;
      status_in = ST_MISSING;
      case (kind_ff)
         KIND_LOOKUP: begin
            slot_in   = 7'(hit ? hit_slot : new_slot);
            status_in = hit ? ST_HIT : ST_SEND;
         end
         KIND_OVERRIDE: begin
            slot_in   = 7'(SLOTS);
            status_in = ovr_match ? ST_HIT : ST_SEND;
         end
         KIND_UNCACHE: begin
            if (hit) begin
               slot_in   = 7'(hit_slot);
               status_in = ST_HIT;
            end else if (ovr_match) begin
               slot_in   = 7'(SLOTS);
               status_in = ST_HIT;
            end
         end
         default: begin
            slot_in   = 7'd0;
            status_in = ST_MISSING;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         counter_ff   <= '0;
         ovr_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (go) begin
            if (kind_ff == KIND_LOOKUP) begin
               counter_ff <= counter_ff + 64'd1;
            end
            if (kind_ff == KIND_OVERRIDE) begin
               ovr_valid_ff <= 1'b1;
            end else if ((kind_ff == KIND_UNCACHE) && !hit && ovr_match) begin
               ovr_valid_ff <= 1'b0;
            end
         end
      end
   end

   // Counts down the cycles the minimum needs to ripple through all cells.
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= (SlotW+1)'(SLOTS);
      end else if (|(wr_vec | touch_vec | clr_vec)) begin
         settle_ff <= (SlotW+1)'(SLOTS);
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && req_valid) begin
         kind_ff <= req_kind;
         id_ff   <= req_buffer_id;
      end
      if (go) begin
         slot_ff   <= slot_in;
         status_ff <= status_in;
         if (kind_ff == KIND_OVERRIDE) begin
            ovr_id_ff <= id_ff;
         end
      end
   end

   assign rsp_slot   = slot_ff;
   assign rsp_status = status_ff;

   // Ids in the cell row are unique, so at most one cell may match.
   a_onehot_match: assert property (@(posedge clock) disable iff (reset)
      exec |-> $onehot0(match_vec))
      else $error("more than one cell matched the id");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wr_vec | touch_vec | clr_vec))
      else $error("more than one cell updated in a cycle");

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid)
      else $error("response did not follow execution");

   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      (go && (kind_ff == KIND_LOOKUP)) |=> (counter_ff == $past(counter_ff) + 64'd1))
      else $error("stamp counter did not advance on lookup");
endmodule

// File: rtl/lbsc_cell.sv
// ----------------------------------------------------------------------------
// lbsc_cell: one cache entry
// Holds valid, id and stamp for one slot, compares the probe id, and folds
// its stamp into the minimum passed in from its lower neighbor, registering
// the result for its upper neighbor.
// ----------------------------------------------------------------------------
module lbsc_cell
   import lbsc_pkg::*;
#(
   parameter int SlotW = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [63:0]       probe_id,
   input  logic              wr_en,
   input  logic [63:0]       wr_stamp,
   input  logic              touch_en,
   input  logic              clr_en,
   input  logic [SlotW-1:0]  my_slot,
   input  logic              min_have_i,
   input  logic [63:0]       min_stamp_i,
   input  logic [SlotW-1:0]  min_slot_i,
   output logic              min_have_o,
   output logic [63:0]       min_stamp_o,
   output logic [SlotW-1:0]  min_slot_o,
   output logic              match
);
   logic             valid_ff;
   logic [63:0]      id_ff;
   logic [63:0]      stamp_ff;
   logic             take;
   logic             min_have_ff;
   logic [63:0]      min_stamp_ff;
   logic [SlotW-1:0] min_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= 1'b1;
      end else if (clr_en) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_ff <= probe_id;
      end
      if (wr_en || touch_en) begin
         stamp_ff <= wr_stamp;
      end
   end

   assign match = valid_ff && (id_ff == probe_id);
   // Strict compare keeps the lowest slot on equal stamps.
   assign take = valid_ff && (!min_have_i || (stamp_ff < min_stamp_i));

   always_ff @(posedge clock) begin
      if (reset) begin
         min_have_ff <= 1'b0;
      end else begin
         min_have_ff <= min_have_i || valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      min_stamp_ff <= take ? stamp_ff : min_stamp_i;
      min_slot_ff  <= take ? my_slot : min_slot_i;
   end

   assign min_have_o  = min_have_ff;
   assign min_stamp_o = min_stamp_ff;
   assign min_slot_o  = min_slot_ff;
endmodule

// File: rtl/lbsc_free_stack.sv
// ----------------------------------------------------------------------------
// lbsc_free_stack: free slot stack
// Stack of free slots; reset state is slot 0 on top, ascending below.
// ----------------------------------------------------------------------------
module lbsc_free_stack
   import lbsc_pkg::*;
#(
   parameter int Slots = 64,
   parameter int SlotW = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop,
   input  logic              push,
   input  logic [SlotW-1:0]  push_slot,
   output logic              empty,
   output logic [SlotW-1:0]  top_slot
);
   logic [SlotW-1:0] stack_ff [Slots];
   logic [SlotW:0]   count_ff;
   logic [SlotW:0]   low_ff;
   logic [SlotW-1:0] rd_ff;
   logic [SlotW-1:0] top_idx;
   logic             pop_ok, push_ok;

   assign top_idx = SlotW'(count_ff - 1'b1);
   assign empty   = (count_ff == '0);
   assign pop_ok  = pop && !empty;
   assign push_ok = push && !pop_ok && (count_ff < (SlotW+1)'(Slots));

   // Entries below the lowest count reached since reset were never written
   // and still hold their reset order, so slot Slots - count is on top there.
   // Otherwise the top is read through the register rd_ff; the controller never
   // uses the top after an update before rd_ff has taken up the new top.
   assign top_slot = (count_ff <= low_ff) ?
                     SlotW'((SlotW+1)'(Slots) - count_ff) : rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= (SlotW+1)'(Slots);
         low_ff   <= (SlotW+1)'(Slots);
      end else if (pop_ok) begin
         count_ff <= count_ff - 1'b1;
         if (count_ff == low_ff) begin
            low_ff <= count_ff - 1'b1;
         end
      end else if (push_ok) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!reset && push_ok) begin
         stack_ff[count_ff[SlotW-1:0]] <= push_slot;
      end
      rd_ff <= stack_ff[top_idx];
   end
endmodule

// File: tb/sv/tb_checker.sv
// ----------------------------------------------------------------------------
// tb_checker: response checker for the buffer slot cache
// Watches the request and response channels, keeps its own copy of the slot
// table, free stack, stamp counter and override, and compares each response.
// ----------------------------------------------------------------------------
module tb_checker
   import lbsc_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_buffer_id,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [6:0]  rsp_slot,
   input  logic [1:0]  rsp_status,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [6:0] slot;
      logic [1:0] status;
   } slot_answer_type;

   logic        cached[SLOTS];
   logic [63:0] cached_id[SLOTS];
   logic [63:0] cached_stamp[SLOTS];
   int          free_slots[$];
   logic [63:0] stamp_now;
   logic [63:0] pinned_id;
   logic        pinned;
   slot_answer_type answers_due[$];

   function automatic int find_cached(logic [63:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (cached[i] && cached_id[i] == id) return i;
      return -1;
   endfunction

   function automatic slot_answer_type resolve_request(logic [1:0] kind, logic [63:0] id);
      slot_answer_type a;
      int hit;
      int victim;
      a.slot = '0;
      a.status = ST_MISSING;
      case (kind)
         KIND_LOOKUP: begin
            hit = find_cached(id);
            if (hit >= 0) begin
               cached_stamp[hit] = stamp_now++;
               a.slot = 7'(hit);
               a.status = ST_HIT;
            end else begin
               if (free_slots.size() > 0) begin
                  victim = free_slots.pop_back();
               end else begin
                  victim = -1;
                  for (int i = 0; i < SLOTS; i++)
                     if (cached[i] && (victim < 0 || cached_stamp[i] < cached_stamp[victim]))
                        victim = i;
               end
               cached[victim] = 1'b1;
               cached_id[victim] = id;
               cached_stamp[victim] = stamp_now++;
               a.slot = 7'(victim);
               a.status = ST_SEND;
            end
         end
         KIND_OVERRIDE: begin
            a.slot = 7'(SLOTS);
            if (pinned && pinned_id == id) begin
               a.status = ST_HIT;
            end else begin
               pinned_id = id;
               pinned = 1'b1;
               a.status = ST_SEND;
            end
         end
         KIND_UNCACHE: begin
            hit = find_cached(id);
            if (hit >= 0) begin
               cached[hit] = 1'b0;
               free_slots.push_back(hit);
               a.slot = 7'(hit);
               a.status = ST_HIT;
            end else if (pinned && pinned_id == id) begin
               pinned = 1'b0;
               a.slot = 7'(SLOTS);
               a.status = ST_HIT;
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      slot_answer_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) cached[i] = 1'b0;
         free_slots = {};
         // Slot 0 ends up on top, the back of the queue.
         for (int i = SLOTS - 1; i >= 0; i--) free_slots.push_back(i);
         stamp_now = '0;
         pinned = 1'b0;
         pinned_id = '0;
         answers_due = {};
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("unexpected response slot=%0d status=%0d", rsp_slot, rsp_status);
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            answers_due.push_back(resolve_request(req_kind, req_buffer_id));
      end
      pending = answers_due.size();
   end
endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the buffer slot cache
// Drives directed and random lookup, override and uncache requests with
// random idling on both sides; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module tb;
   import lbsc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 64;
   localparam int QUIET_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [63:0] req_buffer_id;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [6:0]  rsp_slot;
   logic [1:0]  rsp_status;
   int          fail_count;
   int          pending;
   int          quiet_cycles;
   logic        calm;
   logic [63:0] id_pool[48];

   lru_buffer_slot_cache #(.SLOTS(SLOTS)) uut (.*);

   tb_checker #(.SLOTS(SLOTS)) checker_i (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Receiver stalls in bursts until the calm phase.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic send_request(logic [1:0] kind, logic [63:0] id);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_buffer_id <= id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         req_kind <= 2'($urandom);
         req_buffer_id <= {$urandom, $urandom};
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   function automatic logic [63:0] pick_id();
      if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
      return id_pool[$urandom_range(0, 47)];
   endfunction

   initial begin
      logic [1:0] kind;
      calm = 1'b0;
      quiet_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_LOOKUP;
      req_buffer_id = '0;
      for (int i = 0; i < 48; i++) id_pool[i] = {$urandom, $urandom};
      // The first 40 pool ids carry their index in the low half, random bits above.
      for (int i = 0; i < 40; i++) id_pool[i] = 64'(i) ^ {$urandom, 32'h0};
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes, each kind, override hit and clear, misses.
      send_request(KIND_LOOKUP, '0);
      send_request(KIND_LOOKUP, '1);
      send_request(KIND_LOOKUP, '0);
      send_request(KIND_OVERRIDE, '1);
      send_request(KIND_OVERRIDE, '1);
      send_request(KIND_OVERRIDE, 64'h5555_5555_5555_5555);
      send_request(KIND_UNCACHE, 64'h5555_5555_5555_5555);
      send_request(KIND_UNCACHE, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(KIND_UNCACHE, '0);
      send_request(2'd3, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(KIND_UNCACHE, '1);
      send_request(KIND_LOOKUP, 64'h1234);
      // Fill the table past capacity so the eviction path runs.
      for (int i = 0; i < SLOTS + 6; i++) send_request(KIND_LOOKUP, 64'h1000 + i);
      send_request(KIND_LOOKUP, 64'h1000 + SLOTS + 2);
      send_request(KIND_UNCACHE, 64'h1000 + SLOTS + 3);
      send_request(KIND_LOOKUP, 64'h9999);

      for (int n = 0; n < 1700; n++) begin
         if (n == 1500) calm = 1'b1;
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: kind = KIND_LOOKUP;
            11, 12: kind = KIND_OVERRIDE;
            13, 14, 15, 16, 17, 18: kind = KIND_UNCACHE;
            default: kind = 2'd3;
         endcase
         send_request(kind, pick_id());
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end
endmodule
